>>> rtl/sgwm_pkg.sv
// Package for the scan-gated window mean block.
// Holds the shared widths, reset values, register codes and the window entry type.
// Depends on nothing.
`timescale 1ns / 1ps

package sgwm_pkg;

	// Window geometry and field widths.
	localparam int MAX_HALF_WIDTH = 15;
	localparam int RANGE_BITS     = 16;
	localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1;
	localparam int ADDR_BITS      = $clog2(WIN_DEPTH);
	localparam int POS_BITS       = $clog2(WIN_DEPTH + 1);
	localparam int HW_BITS        = $clog2(MAX_HALF_WIDTH + 1);
	localparam int HW_REG_BITS    = 4;
	localparam int MSD_BITS       = 16;
	localparam int THR_BITS       = MSD_BITS + HW_BITS;
	localparam int SUM_BITS       = RANGE_BITS + POS_BITS;

	// Configuration port.
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [HW_REG_BITS-1:0] HW_RESET  = HW_REG_BITS'(2);
	localparam logic [MSD_BITS-1:0]    MSD_RESET = MSD_BITS'(100);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_HALF_WIDTH = 1'b0,
		CFG_MAX_STEP   = 1'b1
	} sgwm_cfg_idx_t;

	// One stored reading of the window.
	typedef struct packed {
		logic                  vld;
		logic [RANGE_BITS-1:0] rng;
	} sgwm_entry_t;

endpackage

>>> rtl/sgwm_in_if.sv
// Input channel of the window mean block: one range reading per beat.
// Depends on sgwm_pkg.
`timescale 1ns / 1ps

interface sgwm_in_if
	import sgwm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [RANGE_BITS-1:0] range_in;
	logic                  valid_in;
	logic                  last_in;

	modport source (output valid, output range_in, output valid_in, output last_in, input ready);
	modport sink   (input valid, input range_in, input valid_in, input last_in, output ready);
endinterface

>>> rtl/sgwm_out_if.sv
// Result channel of the window mean block: one filtered reading per beat.
// Depends on sgwm_pkg.
`timescale 1ns / 1ps

interface sgwm_out_if
	import sgwm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [RANGE_BITS-1:0] range_out;
	logic                  valid_out;
	logic                  last_out;

	modport source (output valid, output range_out, output valid_out, output last_out, input ready);
	modport sink   (input valid, input range_out, input valid_out, input last_out, output ready);
endinterface

>>> rtl/sgwm_cfg_if.sv
// Configuration write channel of the window mean block: register index and data per beat.
// Depends on sgwm_pkg.
`timescale 1ns / 1ps

interface sgwm_cfg_if
	import sgwm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sgwm_win_ram.sv
// Circular window store of the window mean block: one write and one registered read port.
// Depends on sgwm_pkg.
`timescale 1ns / 1ps

module sgwm_win_ram
	import sgwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  sgwm_entry_t          wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output sgwm_entry_t          rdata
);

	sgwm_entry_t mem [2**ADDR_BITS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/sgwm_div.sv
// Serial restoring divider of the window mean block: one quotient bit per cycle.
// Depends on sgwm_pkg.
`timescale 1ns / 1ps

module sgwm_div
	import sgwm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUM_BITS-1:0] dividend,
	input  logic [POS_BITS-1:0] divisor,
	output logic                done,
	output logic [SUM_BITS-1:0] quotient
);

	localparam int STEP_BITS = $clog2(SUM_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	logic [SUM_BITS-1:0]  quo_q;
	logic [POS_BITS-1:0]  rem_q;
	logic [POS_BITS-1:0]  div_q;
	logic [POS_BITS:0]    shifted;
	logic [POS_BITS:0]    trial;
	logic                 fits;

	// Shift in the next dividend bit and try the subtraction.
	always_comb begin
		shifted = {rem_q, quo_q[SUM_BITS-1]};
		trial   = shifted - {1'b0, div_q};
		fits    = shifted >= {1'b0, div_q};
	end

	// Control: busy until every dividend bit has been shifted through, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(SUM_BITS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register turns into the quotient bit by bit.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= trial[POS_BITS-1:0];
				quo_q <= {quo_q[SUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[POS_BITS-1:0];
				quo_q <= {quo_q[SUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/scan_gated_window_mean_core.sv
// Top level of the scan-gated window mean block: sequencer, accumulator and output register.
// Depends on sgwm_pkg, the three channel interfaces, sgwm_win_ram and sgwm_div.
//
// Usage: readings of a laser scan enter on the reading channel, one per beat, each with
// its range, a valid bit and a last-of-scan mark. Filtered readings leave on the result
// channel. The cfg channel writes half_width (index 0) and max_step_diff (index 1); it is
// always ready and must only be used while the block is idle.
// A reading is written into a circular window memory in the cycle it is accepted. The
// reading half_width positions back is then filtered: its centre and up to 2*half_width
// neighbours are read one per cycle from the memory, accumulated, and the sum is divided
// by the count in a serial divider of one bit per cycle. The single memory read port and
// the divider set the time for one result; a reading that releases a result keeps the input
// closed until its last result has entered the result register.
// Readings that give no result leave the input ready for the next reading.
// At the last reading of a scan all pending readings are flushed, oldest first, at the
// same cost per result; the window is then emptied without a clearing pass.
// The result register holds a finished beat while the receiver stalls; the next reading
// may still be accepted, but a further result waits until that register is free.
// Reset restores half_width 2 and max_step_diff 100 and empties the window.
`timescale 1ns / 1ps

module scan_gated_window_mean_core
	import sgwm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sgwm_cfg_if.sink   cfg,
	sgwm_in_if.sink    reading,
	sgwm_out_if.source result
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CENTRE = 7'b0000010,
		S_NBR    = 7'b0000100,
		S_DRAIN  = 7'b0001000,
		S_START  = 7'b0010000,
		S_WAIT   = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [HW_REG_BITS-1:0] hw_q;
	logic [MSD_BITS-1:0]    msd_q;
	logic [POS_BITS-1:0]    seen_q;
	logic [ADDR_BITS-1:0]   wp_q;
	logic [POS_BITS-1:0]    pos_q;
	logic                   flush_q;
	logic [HW_BITS-1:0]     d_q;
	logic                   side_q;
	logic [THR_BITS-1:0]    thr_q;

	logic                   rd_centre_s1;
	logic                   rd_act_s1;
	logic [THR_BITS-1:0]    thr_s1;

	logic [RANGE_BITS-1:0]  centre_q;
	logic                   cval_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [POS_BITS-1:0]    cnt_q;

	logic                   out_vld_q;
	logic [RANGE_BITS-1:0]  out_rng_q;
	logic                   out_val_q;
	logic                   out_last_q;

	logic [HW_BITS-1:0]     h_eff;
	logic                   accept_in;
	logic [POS_BITS-1:0]    seen_inc;
	logic                   emit_now;
	logic [POS_BITS-1:0]    first_pos;
	logic [POS_BITS:0]      q_up;
	logic [POS_BITS-1:0]    q_dn;
	logic                   up_act;
	logic                   dn_act;
	logic                   nbr_last;
	logic                   out_free;
	logic [ADDR_BITS-1:0]   raddr;
	sgwm_entry_t            wdata;
	sgwm_entry_t            rdata;
	logic [RANGE_BITS-1:0]  diff;
	logic                   near;
	logic                   div_done;
	logic [SUM_BITS-1:0]    div_quo;

	assign cfg.ready     = 1'b1;
	assign reading.ready = (state_q == S_IDLE);
	assign accept_in     = reading.valid && reading.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q  <= HW_RESET;
			msd_q <= MSD_RESET;
		end else if (cfg.valid) begin
			case (sgwm_cfg_idx_t'(cfg.index))
				CFG_HALF_WIDTH: hw_q  <= cfg.data[HW_REG_BITS-1:0];
				CFG_MAX_STEP:   msd_q <= cfg.data[MSD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective half width, clamped to the window.
	assign h_eff = (int'(hw_q) > MAX_HALF_WIDTH) ? HW_BITS'(MAX_HALF_WIDTH) : HW_BITS'(hw_q);

	// Which reading to filter first once the new reading is in the window.
	always_comb begin
		seen_inc  = (int'(seen_q) < WIN_DEPTH) ? seen_q + 1'b1 : seen_q;
		emit_now  = reading.last_in || (seen_inc > POS_BITS'(h_eff));
		first_pos = POS_BITS'(h_eff);
		if (reading.last_in && (POS_BITS'(h_eff) >= seen_inc)) begin
			first_pos = seen_inc - 1'b1;
		end
	end

	// Neighbour positions for the current distance and side.
	always_comb begin
		q_up     = (POS_BITS + 1)'(pos_q) + (POS_BITS + 1)'(d_q);
		q_dn     = pos_q - POS_BITS'(d_q);
		up_act   = q_up < (POS_BITS + 1)'(seen_q);
		dn_act   = POS_BITS'(d_q) <= pos_q;
		nbr_last = side_q && (d_q == h_eff);
		out_free = !out_vld_q || result.ready;
	end

	// Read address: position p lies p entries behind the newest one.
	always_comb begin
		case (state_q)
			S_NBR: begin
				if (side_q) begin
					raddr = wp_q - ADDR_BITS'(q_dn);
				end else begin
					raddr = wp_q - ADDR_BITS'(q_up);
				end
			end
			default: raddr = wp_q - ADDR_BITS'(pos_q);
		endcase
	end

	assign wdata.vld = reading.valid_in;
	assign wdata.rng = reading.range_in;

	sgwm_win_ram u_ram (
		.clk   (clk),
		.we    (accept_in),
		.waddr (wp_q + 1'b1),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer: write the reading, then walk centre and neighbours for each result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seen_q  <= '0;
			wp_q    <= '0;
			pos_q   <= '0;
			flush_q <= 1'b0;
			d_q     <= '0;
			side_q  <= 1'b0;
			thr_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						wp_q    <= wp_q + 1'b1;
						seen_q  <= seen_inc;
						flush_q <= reading.last_in;
						pos_q   <= first_pos;
						if (emit_now) begin
							state_q <= S_CENTRE;
						end
					end
				end
				S_CENTRE: begin
					d_q     <= HW_BITS'(1);
					side_q  <= 1'b0;
					thr_q   <= THR_BITS'(msd_q);
					state_q <= (h_eff == '0) ? S_DRAIN : S_NBR;
				end
				S_NBR: begin
					if (side_q) begin
						side_q <= 1'b0;
						d_q    <= d_q + 1'b1;
						thr_q  <= thr_q + THR_BITS'(msd_q);
						if (nbr_last) begin
							state_q <= S_DRAIN;
						end
					end else begin
						side_q <= 1'b1;
					end
				end
				S_DRAIN: state_q <= S_START;
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (flush_q && (pos_q != '0)) begin
							pos_q   <= pos_q - 1'b1;
							state_q <= S_CENTRE;
						end else begin
							if (flush_q) begin
								seen_q <= '0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Tags that travel with each memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_centre_s1 <= 1'b0;
			rd_act_s1    <= 1'b0;
		end else begin
			rd_centre_s1 <= (state_q == S_CENTRE);
			rd_act_s1    <= (state_q == S_NBR) && (side_q ? dn_act : up_act);
		end
	end

	always_ff @(posedge clk) begin
		thr_s1 <= thr_q;
	end

	// Step test against the centre reading.
	always_comb begin
		diff = (rdata.rng > centre_q) ? rdata.rng - centre_q : centre_q - rdata.rng;
		near = THR_BITS'(diff) < thr_s1;
	end

	// Accumulator: the centre starts the sum, admitted neighbours add to it.
	always_ff @(posedge clk) begin
		if (rd_centre_s1) begin
			centre_q <= rdata.rng;
			cval_q   <= rdata.vld;
			sum_q    <= SUM_BITS'(rdata.rng);
			cnt_q    <= POS_BITS'(1);
		end else if (rd_act_s1 && cval_q && rdata.vld && near) begin
			sum_q <= sum_q + SUM_BITS'(rdata.rng);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	sgwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			out_rng_q  <= div_quo[RANGE_BITS-1:0];
			out_val_q  <= cval_q;
			out_last_q <= flush_q && (pos_q == '0);
		end
	end

	assign result.valid     = out_vld_q;
	assign result.range_out = out_rng_q;
	assign result.valid_out = out_val_q;
	assign result.last_out  = out_last_q;

	// The count of readings held never exceeds the window.
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(seen_q) <= WIN_DEPTH)
		else $error("reading count beyond window depth");

	// The divider is never started with an empty count.
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START) |-> (cnt_q != '0))
		else $error("division started with zero count");

	// A mean never exceeds the range width.
	a_mean_fits: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((div_quo >> RANGE_BITS) == '0))
		else $error("mean wider than a range");

	// A neighbour read is only taken while a result is being built.
	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_act_s1 |-> ((state_q == S_NBR) || (state_q == S_DRAIN)))
		else $error("neighbour read outside the walk");

endmodule

>>> bench/tb_scan_gated_window_mean_core.sv
// Self-checking testbench for scan_gated_window_mean_core: a directed table, then random scans.
// It predicts each filtered reading itself, or takes it from a typed table row, and compares each result beat with it.
// Depends on sgwm_pkg, the three channel interfaces and the block itself.
`timescale 1ns / 1ps

module tb_scan_gated_window_mean_core;
	import sgwm_pkg::*;

	// Settling time after the last result: one full result at the widest window, plus margin.
	localparam int SETTLE_CYCLES   = 2 * MAX_HALF_WIDTH + SUM_BITS + 5 + 20;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int ITEMS_PER_PHASE = 45;
	localparam int PHASES          = 8;
	localparam int HOLD_AFTER      = 150;
	localparam int HOLD_CYCLES     = 1200;

	typedef enum bit {ROW_READING, ROW_SETUP} row_kind_t;

	// One row of the directed table; the expected beat is only filled in where typed is set.
	typedef struct {
		row_kind_t             kind;
		logic [HW_REG_BITS-1:0] hw;
		logic [MSD_BITS-1:0]   msd;
		logic [RANGE_BITS-1:0] rng;
		logic                  vld;
		logic                  lst;
		bit                    typed;
		logic [RANGE_BITS-1:0] exp_rng;
		logic                  exp_vld;
		logic                  exp_lst;
	} step_row_t;

	typedef struct {
		logic [RANGE_BITS-1:0] rng;
		logic                  vld;
		logic                  lst;
	} mean_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	sgwm_cfg_if cfg_ch ();
	sgwm_in_if  rd_ch ();
	sgwm_out_if res_ch ();

	scan_gated_window_mean_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.reading (rd_ch),
		.result  (res_ch)
	);

	// Predictor state: held readings, newest first, and the register copies.
	logic [RANGE_BITS-1:0]  win_rng [WIN_DEPTH];
	logic                   win_vld [WIN_DEPTH];
	int unsigned            held;
	logic [HW_REG_BITS-1:0] hw_reg;
	logic [MSD_BITS-1:0]    msd_reg;

	mean_beat_t due_means [$];
	mean_beat_t head_beat;

	int mismatches    = 0;
	int beats_taken   = 0;
	int cycle_count   = 0;
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int hold_left     = 0;
	bit hold_spent    = 1'b0;

	step_row_t plan [0:21] = '{
		// After reset, single-reading scans come back unchanged.
		'{ROW_READING, 4'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1},
		'{ROW_READING, 4'd0, 16'd0, 16'd0,    1'b0, 1'b1, 1'b1, 16'd0,    1'b0, 1'b1},
		'{ROW_READING, 4'd0, 16'd0, 16'd0,    1'b1, 1'b1, 1'b1, 16'd0,    1'b1, 1'b1},
		// Reset setting: a smooth run with an invalid reading and a far outlier at the end.
		'{ROW_READING, 4'd0, 16'd0, 16'd1000, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd1050, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd1100, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd1150, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd5000, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0},
		// No neighbours and a zero step: every reading stands alone.
		'{ROW_SETUP,   4'd0, 16'd0, 16'd0,    1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd300,  1'b1, 1'b0, 1'b1, 16'd300,  1'b1, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd301,  1'b1, 1'b0, 1'b1, 16'd301,  1'b1, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1},
		// Widest window and step; a scan shorter than the window flushes at its end.
		'{ROW_SETUP,   4'd15, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd0,    1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd40000, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0},
		// The window narrows part-way through a scan.
		'{ROW_READING, 4'd0, 16'd0, 16'd2000, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd2100, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_SETUP,   4'd1, 16'd50, 16'd0,   1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd2150, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_READING, 4'd0, 16'd0, 16'd2180, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0}
	};

	// Clock: 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// A neighbour counts when its range is closer than the step allowance for its distance.
	function automatic bit within_step(logic [RANGE_BITS-1:0] a, logic [RANGE_BITS-1:0] b,
			int unsigned gap);
		int unsigned diff;
		diff = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
		return diff < int'(msd_reg) * gap;
	endfunction

	// Truncated mean of the held reading at pos (0 is newest) and its admitted neighbours.
	function automatic logic [RANGE_BITS-1:0] window_mean(int unsigned pos, int unsigned h);
		logic [RANGE_BITS-1:0] centre;
		int unsigned total;
		int unsigned count;
		int unsigned d;
		int unsigned q;
		centre = win_rng[pos];
		if (!win_vld[pos])
			return centre;
		total = centre;
		count = 1;
		for (d = 1; d <= h; d++) begin
			q = pos + d;
			if (q < held && q < WIN_DEPTH && win_vld[q] && within_step(centre, win_rng[q], d)) begin
				total += win_rng[q];
				count++;
			end
			if (d <= pos) begin
				q = pos - d;
				if (q < held && win_vld[q] && within_step(centre, win_rng[q], d)) begin
					total += win_rng[q];
					count++;
				end
			end
		end
		return RANGE_BITS'(total / count);
	endfunction

	// Take one accepted reading into the window and queue the results it releases.
	function automatic void advance_window(logic [RANGE_BITS-1:0] rng, logic vld, logic lst);
		int unsigned h;
		int unsigned start;
		int i;
		h = (hw_reg > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : hw_reg;
		for (i = WIN_DEPTH - 1; i > 0; i--) begin
			win_rng[i] = win_rng[i-1];
			win_vld[i] = win_vld[i-1];
		end
		win_rng[0] = rng;
		win_vld[0] = vld;
		if (held < WIN_DEPTH)
			held++;
		if (!lst) begin
			if (held > h)
				due_means.push_back('{window_mean(h, h), win_vld[h], 1'b0});
			return;
		end
		// End of scan: flush everything still pending, oldest first, then forget the scan.
		start = (h < held) ? h : held - 1;
		for (i = int'(start); i >= 0; i--)
			due_means.push_back('{window_mean(i, h), win_vld[i], i == 0});
		held = 0;
		for (i = 0; i < WIN_DEPTH; i++)
			win_vld[i] = 1'b0;
	endfunction

	// Next random range: mostly a walk near the previous one, sometimes a jump or an extreme.
	function automatic logic [RANGE_BITS-1:0] next_range(logic [RANGE_BITS-1:0] prev);
		int pick;
		int span;
		int val;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			return '0;
		if (pick < 12)
			return '1;
		if (pick < 28)
			return RANGE_BITS'($urandom_range(0, 65535));
		span = (int'(msd_reg) * 2 > 3000) ? 3000 : int'(msd_reg) * 2;
		span += 5;
		val = int'(prev) + int'($urandom_range(0, 2 * span)) - span;
		if (val < 0)
			val = 0;
		if (val > 65535)
			val = 65535;
		return RANGE_BITS'(val);
	endfunction

	// Offer one reading, with random gaps ahead of it; valid stays high after the beat.
	task automatic send_reading(logic [RANGE_BITS-1:0] rng, logic vld, logic lst);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rd_ch.valid    <= 1'b1;
		rd_ch.range_in <= rng;
		rd_ch.valid_in <= vld;
		rd_ch.last_in  <= lst;
		@(posedge clk);
		while (!rd_ch.ready)
			@(posedge clk);
		advance_window(rng, vld, lst);
	endtask

	// Stop offering readings, wait for every expected beat, then let the block go quiet.
	task automatic settle_window();
		rd_ch.valid <= 1'b0;
		while (due_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Write both registers back to back, half_width first.
	task automatic program_window(logic [CFG_DATA_BITS-1:0] hw_word, logic [MSD_BITS-1:0] msd);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_HALF_WIDTH;
		cfg_ch.data  <= hw_word;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		hw_reg = hw_word[HW_REG_BITS-1:0];
		cfg_ch.index <= CFG_MAX_STEP;
		cfg_ch.data  <= msd;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		msd_reg = msd;
		cfg_ch.valid <= 1'b0;
	endtask

	// Result side: check each beat against the oldest expectation, then choose the next ready.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			if (due_means.size() == 0) begin
				$error("result beat with nothing expected: range_out %0d", res_ch.range_out);
				mismatches++;
			end else begin
				head_beat = due_means.pop_front();
				if (res_ch.range_out !== head_beat.rng) begin
					$error("range_out: expected %0d, got %0d", head_beat.rng, res_ch.range_out);
					mismatches++;
				end
				if (res_ch.valid_out !== head_beat.vld) begin
					$error("valid_out: expected %0b, got %0b", head_beat.vld, res_ch.valid_out);
					mismatches++;
				end
				if (res_ch.last_out !== head_beat.lst) begin
					$error("last_out: expected %0b, got %0b", head_beat.lst, res_ch.last_out);
					mismatches++;
				end
			end
			beats_taken++;
		end
		// Once in the run the receiver holds off for a long stretch so the block backs up.
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (!hold_spent && beats_taken >= HOLD_AFTER) begin
			hold_spent = 1'b1;
			hold_left  = HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_scan_gated_window_mean_core: done, errors");
			$finish;
		end
	end

	// Stimulus: reset, the directed table, then random scans over several settings.
	initial begin
		logic [RANGE_BITS-1:0] walk;
		logic [HW_REG_BITS-1:0] hw_pick;
		logic [MSD_BITS-1:0] msd_pick;
		int phase;
		int sent;
		int scan_len;
		int k;
		int pick;

		arst_n         <= 1'b0;
		rd_ch.valid    <= 1'b0;
		rd_ch.range_in <= '0;
		rd_ch.valid_in <= 1'b0;
		rd_ch.last_in  <= 1'b0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= CFG_HALF_WIDTH;
		cfg_ch.data    <= '0;

		hw_reg  = HW_RESET;
		msd_reg = MSD_RESET;
		held    = 0;
		for (k = 0; k < WIN_DEPTH; k++) begin
			win_rng[k] = '0;
			win_vld[k] = 1'b0;
		end

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETUP) begin
				settle_window();
				program_window(CFG_DATA_BITS'(plan[i].hw), plan[i].msd);
			end else begin
				send_reading(plan[i].rng, plan[i].vld, plan[i].lst);
				if (plan[i].typed)
					due_means[due_means.size()-1] = '{plan[i].exp_rng, plan[i].exp_vld,
						plan[i].exp_lst};
			end
		end

		// Random scans, one setting and one idling pattern per phase.
		walk = 16'd1000;
		for (phase = 0; phase < PHASES; phase++) begin
			settle_window();
			case (phase)
				0: begin hw_pick = 4'd2;  msd_pick = 16'($urandom_range(50, 400));  end
				1: begin hw_pick = 4'd15; msd_pick = 16'hFFFF;                      end
				2: begin hw_pick = 4'd0;  msd_pick = 16'($urandom_range(0, 65535)); end
				3: begin hw_pick = 4'($urandom_range(1, 4)); msd_pick = 16'd0;      end
				4: begin
					hw_pick  = 4'($urandom_range(0, 15));
					msd_pick = 16'($urandom_range(0, 65535));
				end
				5: begin hw_pick = 4'd15; msd_pick = 16'($urandom_range(20, 300));  end
				6: begin
					hw_pick  = 4'($urandom_range(1, 5));
					msd_pick = 16'($urandom_range(20, 300));
				end
				default: begin
					hw_pick  = 4'($urandom_range(1, 3));
					msd_pick = 16'($urandom_range(100, 1000));
				end
			endcase
			// The upper data bits of the half_width write carry random noise.
			program_window({12'($urandom_range(0, 4095)), hw_pick}, msd_pick);
			case (phase % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 69; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 69; end
				default: begin src_idle_pct = 29; snk_stall_pct = 29; end
			endcase

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				// Mostly short scans, some long enough to fill the whole window.
				pick = $urandom_range(0, 99);
				if (pick < 60)
					scan_len = $urandom_range(1, 8);
				else if (pick < 85)
					scan_len = $urandom_range(9, 20);
				else
					scan_len = $urandom_range(21, 40);
				// The last scan of a phase is cut short to keep the phase to its size.
				if (scan_len > ITEMS_PER_PHASE - sent)
					scan_len = ITEMS_PER_PHASE - sent;
				for (k = 0; k < scan_len; k++) begin
					walk = next_range(walk);
					send_reading(walk, $urandom_range(0, 99) < 85, k == scan_len - 1);
				end
				sent += scan_len;
			end
		end

		settle_window();
		if (mismatches == 0)
			$display("tb_scan_gated_window_mean_core: done, clean");
		else
			$display("tb_scan_gated_window_mean_core: done, errors");
		$finish;
	end

endmodule
